/* src/assert_macros.svh */
// Assertion macros shared by the rational arithmetic unit RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AST_NOW(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication, disabled while reset is asserted
`define AST_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("check failed");

`endif

/* src/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by the controller, datapath and top level.
package rau_pkg;

	// stream payload widths
	localparam int IN_BITS  = 136;
	localparam int OUT_BITS = 72;
	localparam int CMD_BITS = 4;

	// command codes
	localparam logic [3:0] CMD_NORM = 4'd0;
	localparam logic [3:0] CMD_ADD  = 4'd1;
	localparam logic [3:0] CMD_SUB  = 4'd2;
	localparam logic [3:0] CMD_MUL  = 4'd3;
	localparam logic [3:0] CMD_DIV  = 4'd4;
	localparam logic [3:0] CMD_CMP  = 4'd5;
	localparam logic [3:0] CMD_NEG  = 4'd6;
	localparam logic [3:0] CMD_INC  = 4'd7;
	localparam logic [3:0] CMD_DEC  = 4'd8;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_LOAD, OP_RED_A, OP_RED_B, OP_RED_R,
		OP_MUL_L, OP_MUL_R, OP_MUL_NN, OP_MUL_DD, OP_MUL_DN,
		OP_SUBFLIP, OP_ADDC, OP_SETMUL, OP_SETDIV, OP_CMPC,
		OP_COPYA, OP_NEG, OP_INC, OP_DEC, OP_DIVZ, OP_FIN
	} op_t;

	typedef struct packed {
		logic go;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic       done;
		logic       den_zero;
		logic       b_zero;
		logic       sign_eq;
		logic       out_free;
		logic [3:0] cmd;
	} dp_stat_t;

endpackage

/* src/rau_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle, wrapped product plus overflow.
// Depends on nothing; used by the rau datapath.
module rau_mul #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	output logic             done,
	output logic [WIDTH-1:0] prod,
	output logic             ovf
);
	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] hi_q, lo_q, mc_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [WIDTH:0]   sum;

	// add multiplicand when the low bit is set
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the partial product right
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= y;
			mc_q <= x;
		end else if (busy_q) begin
			hi_q <= sum[WIDTH:1];
			lo_q <= {sum[0], lo_q[WIDTH-1:1]};
		end
	end

	assign done = done_q;
	assign prod = lo_q;
	assign ovf  = (hi_q != '0);
endmodule

/* src/rau_reduce.sv */
// Fraction reduction: binary gcd, then two restoring divisions by the gcd.
// Depends on nothing; used by the rau datapath.
module rau_reduce #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] n,
	input  logic [WIDTH-1:0] d,
	output logic             done,
	output logic [WIDTH-1:0] num,
	output logic [WIDTH-1:0] den,
	output logic             is_zero
);
	localparam int CW = $clog2(WIDTH + 1);
	localparam int KW = $clog2(WIDTH);

	typedef enum logic [1:0] {S_IDLE, S_GCD, S_DIVN, S_DIVD} state_t;

	state_t           state_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [KW-1:0]    k_q;
	logic [WIDTH-1:0] u_q, v_q, g_q, n_q, d_q, q_q, rem_q, num_q, den_q;
	logic             zero_q;
	logic [WIDTH:0]   trial;
	logic             ge;
	logic [WIDTH-1:0] q_next, rem_next;

	// one restoring division step
	always_comb begin
		trial    = {rem_q, q_q[WIDTH-1]};
		ge       = (trial >= {1'b0, g_q});
		rem_next = ge ? WIDTH'(trial - {1'b0, g_q}) : trial[WIDTH-1:0];
		q_next   = {q_q[WIDTH-2:0], ge};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (n == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_GCD;
						end
					end
				end
				S_GCD: begin
					if (u_q == '0 || v_q == '0) begin
						cnt_q   <= CW'(WIDTH);
						state_q <= S_DIVN;
					end
				end
				S_DIVN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						cnt_q   <= CW'(WIDTH);
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// gcd and divider registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					u_q    <= n;
					v_q    <= d;
					n_q    <= n;
					d_q    <= d;
					k_q    <= '0;
					zero_q <= (n == '0);
					num_q  <= '0;
					den_q  <= WIDTH'(1);
				end
			end
			S_GCD: begin
				if (u_q == '0 || v_q == '0) begin
					g_q   <= ((u_q == '0) ? v_q : u_q) << k_q;
					q_q   <= n_q;
					rem_q <= '0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
			end
			S_DIVN: begin
				if (cnt_q == CW'(1)) begin
					num_q <= q_next;
					q_q   <= d_q;
					rem_q <= '0;
				end else begin
					q_q   <= q_next;
					rem_q <= rem_next;
				end
			end
			S_DIVD: begin
				q_q   <= q_next;
				rem_q <= rem_next;
				if (cnt_q == CW'(1)) begin
					den_q <= q_next;
				end
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign num     = num_q;
	assign den     = den_q;
	assign is_zero = zero_q;
endmodule

/* src/rau_dp.sv */
// Datapath: operand and result registers, shared multiplier and reducer, output register.
// Depends on rau_pkg, rau_mul and rau_reduce.
module rau_dp
	import rau_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [IN_BITS-1:0]  s_tdata,
	input  logic [CMD_BITS-1:0] s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_BITS-1:0] m_tdata
);
	logic [3:0]       cmd_q;
	logic             as_q, bs_q, rs_q;
	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q, rn_q, rd_q, t0_q, t1_q;
	logic             ovf_q, less_q, eq_q, den_zero_q;
	logic [1:0]       status_q;
	op_t              red_sel_q, mul_sel_q;
	logic             m_valid_q;
	logic [OUT_BITS-1:0] m_data_q;

	logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
	logic             in_binary, in_den_zero;
	logic             mul_start, red_start, mul_done, red_done, mul_ovf, red_zero;
	logic [WIDTH-1:0] mul_x, mul_y, mul_p, red_n, red_d, red_num, red_den;
	logic [WIDTH:0]   t_sum, a_sum;
	logic             fin_ovf;
	logic             bs_eff;

	// unpack and cut the inbound operands
	assign in_an       = WIDTH'(s_tdata[32:1]);
	assign in_ad       = WIDTH'(s_tdata[64:33]);
	assign in_bn       = WIDTH'(s_tdata[97:66]);
	assign in_bd       = WIDTH'(s_tdata[129:98]);
	assign in_binary   = (s_tuser >= CMD_ADD) && (s_tuser <= CMD_CMP);
	assign in_den_zero = (in_ad == '0) || (in_binary && (in_bd == '0));

	// multiplier and reducer operand select
	always_comb begin
		case (cmd.op)
			OP_MUL_L:  begin mul_x = an_q; mul_y = bd_q; end
			OP_MUL_R:  begin mul_x = bn_q; mul_y = ad_q; end
			OP_MUL_NN: begin mul_x = an_q; mul_y = bn_q; end
			OP_MUL_DD: begin mul_x = ad_q; mul_y = bd_q; end
			default:   begin mul_x = ad_q; mul_y = bn_q; end
		endcase
		case (cmd.op)
			OP_RED_A: begin red_n = an_q; red_d = ad_q; end
			OP_RED_B: begin red_n = bn_q; red_d = bd_q; end
			default:  begin red_n = rn_q; red_d = rd_q; end
		endcase
	end

	assign mul_start = cmd.go && (cmd.op inside {OP_MUL_L, OP_MUL_R, OP_MUL_NN,
		OP_MUL_DD, OP_MUL_DN});
	assign red_start = cmd.go && (cmd.op inside {OP_RED_A, OP_RED_B, OP_RED_R});

	rau_mul #(.WIDTH(WIDTH)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.prod   (mul_p),
		.ovf    (mul_ovf)
	);

	rau_reduce #(.WIDTH(WIDTH)) u_red (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (red_start),
		.n       (red_n),
		.d       (red_d),
		.done    (red_done),
		.num     (red_num),
		.den     (red_den),
		.is_zero (red_zero)
	);

	// cross-product sum and increment sum with carry
	assign t_sum   = {1'b0, t0_q} + {1'b0, t1_q};
	assign a_sum   = {1'b0, an_q} + {1'b0, ad_q};
	assign fin_ovf = ovf_q || ((rn_q >> 32) != '0) || ((rd_q >> 32) != '0);

	// operand and result registers
	always_ff @(posedge clk) begin
		if (mul_done) begin
			ovf_q <= ovf_q | mul_ovf;
			case (mul_sel_q)
				OP_MUL_L, OP_MUL_NN: t0_q <= mul_p;
				OP_MUL_R, OP_MUL_DN: t1_q <= mul_p;
				default:             rd_q <= mul_p;
			endcase
		end
		if (red_done) begin
			case (red_sel_q)
				OP_RED_A: begin
					an_q <= red_num;
					ad_q <= red_den;
					if (red_zero) as_q <= 1'b1;
				end
				OP_RED_B: begin
					bn_q <= red_num;
					bd_q <= red_den;
					if (red_zero) bs_q <= 1'b1;
				end
				default: begin
					rn_q <= red_num;
					rd_q <= red_den;
					if (red_zero) rs_q <= 1'b1;
				end
			endcase
		end
		if (cmd.go) begin
			if (mul_start) mul_sel_q <= cmd.op;
			if (red_start) red_sel_q <= cmd.op;
			unique case (cmd.op)
				OP_LOAD: begin
					cmd_q      <= s_tuser;
					as_q       <= s_tdata[0];
					an_q       <= in_an;
					ad_q       <= in_ad;
					bs_q       <= s_tdata[65];
					bn_q       <= in_bn;
					bd_q       <= in_bd;
					rs_q       <= 1'b1;
					rn_q       <= '0;
					rd_q       <= WIDTH'(1);
					ovf_q      <= 1'b0;
					less_q     <= 1'b0;
					eq_q       <= 1'b0;
					den_zero_q <= in_den_zero;
					status_q   <= in_den_zero ? ST_ZDEN : ST_OK;
				end
				OP_SUBFLIP: begin
					if (bn_q != '0) bs_q <= !bs_q;
				end
				OP_ADDC: begin
					if (as_q == bs_q) begin
						rn_q  <= t_sum[WIDTH-1:0];
						ovf_q <= ovf_q | t_sum[WIDTH];
						rs_q  <= as_q;
					end else if (t0_q > t1_q) begin
						rn_q <= t0_q - t1_q;
						rs_q <= as_q;
					end else begin
						rn_q <= t1_q - t0_q;
						rs_q <= !as_q;
					end
				end
				OP_SETMUL: begin
					rn_q <= t0_q;
					rs_q <= (as_q == bs_q);
				end
				OP_SETDIV: begin
					rn_q <= t0_q;
					rd_q <= t1_q;
					rs_q <= (as_q == bs_q);
				end
				OP_CMPC: begin
					eq_q <= (as_q == bs_q) && (an_q == bn_q) && (ad_q == bd_q);
					if (as_q == bs_q) begin
						less_q <= as_q ? (t0_q < t1_q) : (t0_q > t1_q);
					end else begin
						less_q <= bs_q;
					end
				end
				OP_COPYA: begin
					rs_q <= as_q;
					rn_q <= an_q;
					rd_q <= ad_q;
				end
				OP_NEG: begin
					rs_q <= (an_q != '0) ? !as_q : as_q;
					rn_q <= an_q;
					rd_q <= ad_q;
				end
				OP_INC: begin
					rd_q <= ad_q;
					if (as_q) begin
						rn_q  <= a_sum[WIDTH-1:0];
						ovf_q <= ovf_q | a_sum[WIDTH];
						rs_q  <= 1'b1;
					end else if (an_q > ad_q) begin
						rn_q <= an_q - ad_q;
						rs_q <= 1'b0;
					end else begin
						rn_q <= ad_q - an_q;
						rs_q <= 1'b1;
					end
				end
				OP_DEC: begin
					rd_q <= ad_q;
					if (!as_q) begin
						rn_q  <= a_sum[WIDTH-1:0];
						ovf_q <= ovf_q | a_sum[WIDTH];
						rs_q  <= 1'b0;
					end else if (an_q >= ad_q) begin
						rn_q <= an_q - ad_q;
						rs_q <= 1'b1;
					end else begin
						rn_q <= ad_q - an_q;
						rs_q <= 1'b0;
					end
				end
				OP_DIVZ: status_q <= ST_DIVZ;
				OP_FIN: begin
					m_data_q <= {2'b00, fin_ovf, status_q, eq_q, less_q,
						32'(rd_q), 32'(rn_q), rs_q};
				end
				default: ;
			endcase
		end
	end

	// output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.go && cmd.op == OP_FIN) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// sign of B as it stands once a finishing reduction of B has landed
	assign bs_eff = bs_q | (red_done && (red_sel_q == OP_RED_B) && red_zero);

	assign stat.done     = mul_done | red_done;
	assign stat.den_zero = den_zero_q;
	assign stat.b_zero   = (bn_q == '0);
	assign stat.sign_eq  = (as_q == bs_eff);
	assign stat.out_free = !m_valid_q || m_tready;
	assign stat.cmd      = cmd_q;
endmodule

/* src/rau_ctrl.sv */
// Controller: steps the datapath through the micro-operations of each command.
// Depends on rau_pkg.
module rau_ctrl
	import rau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_WAIT, S_OUT} state_t;

	state_t state_q;
	op_t    op_q, nxt;
	logic   multi;

	// micro-operation that follows the current one
	function automatic op_t next_op(op_t op, dp_stat_t st);
		op_t r;
		r = OP_FIN;
		unique case (op)
			OP_RED_A: r = OP_RED_B;
			OP_RED_B: begin
				case (st.cmd)
					CMD_ADD: r = OP_MUL_L;
					CMD_SUB: r = OP_SUBFLIP;
					CMD_MUL: r = OP_MUL_NN;
					CMD_DIV: r = st.b_zero ? OP_DIVZ : OP_MUL_L;
					CMD_CMP: r = st.sign_eq ? OP_MUL_L : OP_CMPC;
					CMD_NEG: r = OP_NEG;
					CMD_INC: r = OP_INC;
					CMD_DEC: r = OP_DEC;
					default: r = OP_COPYA;
				endcase
			end
			OP_SUBFLIP: r = OP_MUL_L;
			OP_MUL_L:   r = (st.cmd == CMD_DIV) ? OP_MUL_DN : OP_MUL_R;
			OP_MUL_R:   r = (st.cmd == CMD_CMP) ? OP_CMPC : OP_MUL_DD;
			OP_MUL_NN:  r = OP_MUL_DD;
			OP_MUL_DD:  r = (st.cmd == CMD_MUL) ? OP_SETMUL : OP_ADDC;
			OP_MUL_DN:  r = OP_SETDIV;
			OP_ADDC, OP_SETMUL, OP_SETDIV, OP_INC, OP_DEC: r = OP_RED_R;
			default:    r = OP_FIN;
		endcase
		return r;
	endfunction

	assign nxt   = next_op(op_q, stat);
	assign multi = op_q inside {OP_RED_A, OP_RED_B, OP_RED_R, OP_MUL_L, OP_MUL_R,
		OP_MUL_NN, OP_MUL_DD, OP_MUL_DN};

	// command to the datapath
	always_comb begin
		s_tready = (state_q == S_IDLE);
		cmd.go   = 1'b0;
		cmd.op   = op_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.go = s_tvalid;
				cmd.op = OP_LOAD;
			end
			S_ISSUE: cmd.go = 1'b1;
			S_OUT: begin
				cmd.go = stat.out_free;
				cmd.op = OP_FIN;
			end
			default: ;
		endcase
	end

	// state and current micro-operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_LOAD;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					op_q    <= stat.den_zero ? OP_FIN : OP_RED_A;
					state_q <= stat.den_zero ? S_OUT : S_ISSUE;
				end
				S_ISSUE: begin
					if (multi) begin
						state_q <= S_WAIT;
					end else begin
						op_q    <= nxt;
						state_q <= (nxt == OP_FIN) ? S_OUT : S_ISSUE;
					end
				end
				S_WAIT: begin
					if (stat.done) begin
						op_q    <= nxt;
						state_q <= (nxt == OP_FIN) ? S_OUT : S_ISSUE;
					end
				end
				S_OUT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* src/rational_arithmetic_unit.sv */
// Rational arithmetic unit: one item at a time, each result reduced by its gcd.
// A zero denominator goes straight to the output; add and subtract take longest, with
// three bit-serial multiplications and three gcd-and-divide reductions. No new item is
// taken until the previous one is through; a finished result waits in the output register
// while the next item is taken. arst_n clears all control. Depends on rau_pkg,
// rau_ctrl, rau_dp and assert_macros.svh.
`include "assert_macros.svh"

module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// a_nonneg, a_num[31:0], a_den[31:0], b_nonneg, b_num[31:0], b_den[31:0], zero pad
	input  logic [IN_BITS-1:0]  s_tdata,
	// command
	input  logic [CMD_BITS-1:0] s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// r_nonneg, r_num[31:0], r_den[31:0], is_less, is_equal, status[1:0], overflow, pad
	output logic [OUT_BITS-1:0] m_tdata
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rau_dp #(.WIDTH(WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// one item in flight: no second transfer right after one
	`AST_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// status never takes the unused code
	`AST_NOW(a_status_code, clk, arst_n, m_tvalid, m_tdata[68:67] != 2'b11)
	// a zero denominator leaves the block only with overflow
	`AST_NOW(a_den_ovf, clk, arst_n, m_tvalid && (m_tdata[64:33] == 32'd0), m_tdata[69])
	// an error result is zero
	`AST_NOW(a_err_zero, clk, arst_n, m_tvalid && (m_tdata[68:67] != 2'b00), m_tdata[32:1] == 32'd0)
endmodule

/* tb/testbench.sv */
// Self-checking testbench for rational_arithmetic_unit: directed table, then random traffic.
// Depends on rau_pkg and the unit's RTL; a rational model predicts all but typed results.
module testbench;
	import rau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDTH       = 32;
	localparam int N_RANDOM    = 2000;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN       = 500;
	localparam longint unsigned WMASK = 64'h0000_0000_FFFF_FFFF;

	typedef struct {
		logic [3:0]  cmd;
		logic        a_pos;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic        b_pos;
		logic [31:0] b_num;
		logic [31:0] b_den;
	} operands_t;

	typedef struct {
		logic        r_pos;
		logic [31:0] r_num;
		logic [31:0] r_den;
		logic        lt;
		logic        eq;
		logic [1:0]  status;
		logic        ovf;
	} quotient_t;

	typedef struct {
		operands_t ops;
		bit        typed;
		quotient_t res;
	} vector_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_BITS-1:0]  s_tdata = '0;
	logic [CMD_BITS-1:0] s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_BITS-1:0] m_tdata;

	quotient_t pending_results[$];
	int        mismatches = 0;
	int        stall_cycles = 0;
	bit        calm = 1'b0;

	rational_arithmetic_unit #(.WIDTH(WIDTH)) u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- rational predictor ----------------
	function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic void reduce_rat(inout bit pos, inout longint unsigned n,
			inout longint unsigned d);
		longint unsigned g;
		if (n == 0) begin
			pos = 1'b1;
			d = 1;
			return;
		end
		g = gcd64(n, d);
		n = n / g;
		d = d / g;
	endfunction

	function automatic longint unsigned mul_w(longint unsigned x, longint unsigned y,
			inout bit ovf);
		if (x != 0 && y > WMASK / x) ovf = 1'b1;
		return (x * y) & WMASK;
	endfunction

	function automatic longint unsigned add_w(longint unsigned x, longint unsigned y,
			inout bit ovf);
		if (x > WMASK - y) ovf = 1'b1;
		return (x + y) & WMASK;
	endfunction

	// sum of two rationals, left operand overwritten
	function automatic void sum_rat(inout bit rp, inout longint unsigned rn,
			inout longint unsigned rd, input bit bp, input longint unsigned bn,
			input longint unsigned bd, inout bit ovf);
		longint unsigned l, r;
		l = mul_w(rn, bd, ovf);
		r = mul_w(bn, rd, ovf);
		rd = mul_w(rd, bd, ovf);
		if (rp == bp) rn = add_w(l, r, ovf);
		else if (l > r) rn = (l - r) & WMASK;
		else begin
			rn = (r - l) & WMASK;
			rp = !rp;
		end
		reduce_rat(rp, rn, rd);
	endfunction

	function automatic quotient_t predict_rational(operands_t o);
		quotient_t q;
		bit ap, bp, rp, ovf, binary;
		longint unsigned an, ad, bn, bd, rn, rd, l, r;
		ap = o.a_pos; an = o.a_num; ad = o.a_den;
		bp = o.b_pos; bn = o.b_num; bd = o.b_den;
		binary = (o.cmd >= CMD_ADD && o.cmd <= CMD_CMP);
		q = '{r_pos: 1'b1, r_num: 32'd0, r_den: 32'd1, lt: 1'b0, eq: 1'b0,
			status: ST_OK, ovf: 1'b0};
		ovf = 1'b0;
		if (ad == 0 || (binary && bd == 0)) begin
			q.status = ST_ZDEN;
			return q;
		end
		reduce_rat(ap, an, ad);
		reduce_rat(bp, bn, bd);
		rp = ap; rn = an; rd = ad;
		case (o.cmd)
			CMD_ADD: sum_rat(rp, rn, rd, bp, bn, bd, ovf);
			CMD_SUB: begin
				bp = !bp;
				reduce_rat(bp, bn, bd);
				sum_rat(rp, rn, rd, bp, bn, bd, ovf);
			end
			CMD_MUL: begin
				rp = (ap == bp);
				rn = mul_w(an, bn, ovf);
				rd = mul_w(ad, bd, ovf);
				reduce_rat(rp, rn, rd);
			end
			CMD_DIV: begin
				if (bn == 0) begin
					q.status = ST_DIVZ;
					return q;
				end
				rp = (ap == bp);
				rn = mul_w(an, bd, ovf);
				rd = mul_w(ad, bn, ovf);
				reduce_rat(rp, rn, rd);
			end
			CMD_CMP: begin
				q.eq = (ap == bp && an == bn && ad == bd);
				if (ap == bp) begin
					l = mul_w(an, bd, ovf);
					r = mul_w(bn, ad, ovf);
					q.lt = ap ? (l < r) : (l > r);
				end else q.lt = bp;
				rp = 1'b1; rn = 0; rd = 1;
			end
			CMD_NEG: if (rn != 0) rp = !rp;
			CMD_INC: begin
				if (rp) rn = add_w(rn, rd, ovf);
				else if (rn > rd) rn = rn - rd;
				else begin
					rp = 1'b1;
					rn = rd - rn;
				end
				reduce_rat(rp, rn, rd);
			end
			CMD_DEC: begin
				if (!rp) rn = add_w(rn, rd, ovf);
				else if (rn >= rd) rn = rn - rd;
				else begin
					rp = 1'b0;
					rn = rd - rn;
				end
				reduce_rat(rp, rn, rd);
			end
			default: ;
		endcase
		q.r_pos = rp;
		q.r_num = rn[31:0];
		q.r_den = rd[31:0];
		q.ovf = ovf;
		return q;
	endfunction

	// ---------------- checking ----------------
	task automatic report(string what, longint unsigned want, longint unsigned got);
		$display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
		mismatches++;
	endtask

	// compare each result transfer against the oldest expectation; watch for hangs
	always @(posedge clk) begin
		quotient_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) report("unexpected result", 0, 64'(m_tdata));
			else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.r_pos) report("r_nonneg", want.r_pos, m_tdata[0]);
				if (m_tdata[32:1] !== want.r_num) report("r_num", want.r_num, m_tdata[32:1]);
				if (m_tdata[64:33] !== want.r_den) report("r_den", want.r_den, m_tdata[64:33]);
				if (m_tdata[65] !== want.lt) report("is_less", want.lt, m_tdata[65]);
				if (m_tdata[66] !== want.eq) report("is_equal", want.eq, m_tdata[66]);
				if (m_tdata[68:67] !== want.status)
					report("status", want.status, m_tdata[68:67]);
				if (m_tdata[69] !== want.ovf) report("overflow", want.ovf, m_tdata[69]);
			end
		end
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver backpressure, about 30 percent of cycles unless in the calm stretch
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 30);
	end

	// ---------------- stimulus ----------------
	task automatic send_item(operands_t o, bit typed, quotient_t res);
		while (!calm && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= o.cmd;
		s_tdata  <= {6'd0, o.b_den, o.b_num, o.b_pos, o.a_den, o.a_num, o.a_pos};
		// ready is sampled at the edge itself, before the block updates
		@(posedge clk iff s_tready);
		pending_results.push_back(typed ? res : predict_rational(o));
	endtask

	function automatic logic [31:0] rand_mag(bit nonzero);
		logic [31:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom_range(12);
			4, 5:       v = $urandom_range(1000);
			6:          v = $urandom_range(65535);
			7:          v = 32'hFFFF_FFFF - $urandom_range(3);
			default:    v = $urandom;
		endcase
		if (nonzero && v == 0 && $urandom_range(19) != 0) v = 1;
		return v;
	endfunction

	localparam quotient_t Z_DEN = '{1'b1, 32'd0, 32'd1, 1'b0, 1'b0, ST_ZDEN, 1'b0};
	localparam quotient_t D_ZERO = '{1'b1, 32'd0, 32'd1, 1'b0, 1'b0, ST_DIVZ, 1'b0};
	localparam quotient_t NONE = '{1'b1, 32'd0, 32'd1, 1'b0, 1'b0, ST_OK, 1'b0};
	localparam logic [31:0] MAXV = 32'hFFFF_FFFF;

	vector_t directed[] = '{
		'{'{CMD_NORM, 1'b1, 32'd6, 32'd4, 1'b1, 32'd1, 32'd1}, 1'b1,
			'{1'b1, 32'd3, 32'd2, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{'{CMD_NORM, 1'b0, 32'd0, 32'd7, 1'b1, 32'd1, 32'd0}, 1'b1, NONE},
		'{'{CMD_NORM, 1'b1, 32'd5, 32'd0, 1'b1, 32'd1, 32'd1}, 1'b1, Z_DEN},
		'{'{CMD_ADD, 1'b1, 32'd1, 32'd2, 1'b1, 32'd1, 32'd0}, 1'b1, Z_DEN},
		'{'{CMD_CMP, 1'b0, 32'd1, 32'd2, 1'b1, 32'd1, 32'd0}, 1'b1, Z_DEN},
		'{'{CMD_NEG, 1'b1, 32'd3, 32'd5, 1'b1, 32'd1, 32'd0}, 1'b1,
			'{1'b0, 32'd3, 32'd5, 1'b0, 1'b0, ST_OK, 1'b0}},
		'{'{CMD_DIV, 1'b1, 32'd3, 32'd5, 1'b0, 32'd0, 32'd9}, 1'b1, D_ZERO},
		'{'{CMD_ADD, 1'b1, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3}, 1'b0, NONE},
		'{'{CMD_SUB, 1'b0, 32'd7, 32'd3, 1'b0, 32'd2, 32'd9}, 1'b0, NONE},
		'{'{CMD_MUL, 1'b0, MAXV, 32'd1, 1'b1, MAXV, 32'd3}, 1'b0, NONE},
		'{'{CMD_DIV, 1'b1, MAXV, MAXV - 1, 1'b0, 32'd7, MAXV}, 1'b0, NONE},
		'{'{CMD_CMP, 1'b0, 32'd3, 32'd4, 1'b0, 32'd1, 32'd2}, 1'b0, NONE},
		'{'{CMD_CMP, 1'b1, 32'd2, 32'd4, 1'b1, 32'd1, 32'd2}, 1'b0, NONE},
		'{'{CMD_CMP, 1'b0, 32'd1, 32'd2, 1'b1, 32'd0, 32'd5}, 1'b0, NONE},
		'{'{CMD_CMP, 1'b1, 32'd1, 32'd2, 1'b0, 32'd0, 32'd5}, 1'b0, NONE},
		'{'{CMD_CMP, 1'b1, MAXV, 32'd1, 1'b1, 32'd1, MAXV}, 1'b0, NONE},
		'{'{CMD_INC, 1'b0, 32'd1, 32'd3, 1'b1, 32'd0, 32'd0}, 1'b0, NONE},
		'{'{CMD_INC, 1'b1, MAXV, 32'd1, 1'b1, 32'd0, 32'd0}, 1'b0, NONE},
		'{'{CMD_DEC, 1'b1, 32'd1, 32'd3, 1'b1, 32'd0, 32'd0}, 1'b0, NONE},
		'{'{CMD_DEC, 1'b0, 32'd5, 32'd2, 1'b1, 32'd0, 32'd0}, 1'b0, NONE},
		'{'{CMD_ADD, 1'b1, MAXV, MAXV - 2, 1'b1, MAXV - 1, MAXV}, 1'b0, NONE},
		'{'{CMD_MUL, 1'b1, 32'd65536, 32'd1, 1'b1, 32'd65536, 32'd65536}, 1'b0, NONE},
		'{'{4'd15, 1'b0, 32'd9, 32'd12, 1'b0, MAXV, MAXV}, 1'b0, NONE}
	};

	initial begin
		operands_t o;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed[i]) send_item(directed[i].ops, directed[i].typed, directed[i].res);

		// random traffic
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 800 && n < 1100);
			// hold until every outstanding result has drained
			if (n == 1200) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			o.cmd   = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
			o.a_pos = $urandom_range(1);
			o.a_num = rand_mag(1'b0);
			o.a_den = rand_mag(1'b1);
			o.b_pos = $urandom_range(1);
			o.b_num = rand_mag(1'b0);
			o.b_den = rand_mag(1'b1);
			// make equal operands common enough for compare
			if (o.cmd == CMD_CMP && $urandom_range(3) == 0) begin
				o.b_pos = o.a_pos;
				o.b_num = o.a_num;
				o.b_den = o.a_den;
			end
			send_item(o, 1'b0, NONE);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

/* filelist.f */
+incdir+src
src/rau_pkg.sv
src/rau_mul.sv
src/rau_reduce.sv
src/rau_dp.sv
src/rau_ctrl.sv
src/rational_arithmetic_unit.sv
tb/testbench.sv
